// ===== rtl/core/pespf_pkg.sv =====
// shared types and constants for the program/pes stream packet framer
package pespf_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SKIP_W  = 32;
  localparam int LEN_W   = 16;
  localparam int HIDX_W  = 4;
  localparam int SUB_W   = 2;

  localparam logic [23:0]       WINDOW_RESET  = 24'hFFFFFF;
  localparam logic [23:0]       START_PREFIX  = 24'h000001;
  localparam logic [SKIP_W-1:0] SKIP_SAT      = 32'hFFFFFFFF;
  localparam logic [SKIP_W-1:0] PREFIX_LEN    = 32'd4;
  localparam logic [HIDX_W-1:0] PACK_FIXED    = 4'd10;

  localparam logic [BYTE_W-1:0] ID_PROG_END   = 8'hB9;
  localparam logic [BYTE_W-1:0] ID_PACK       = 8'hBA;
  localparam logic [BYTE_W-1:0] ID_SYSTEM     = 8'hBB;
  localparam logic [BYTE_W-1:0] ID_PES_FIRST  = 8'hBC;

  localparam logic [BYTE_W-1:0] PREFIX_ZERO   = 8'h00;
  localparam logic [BYTE_W-1:0] PREFIX_ONE    = 8'h01;

  localparam logic [SUB_W-1:0]  SUB_ZERO_A    = 2'd0;
  localparam logic [SUB_W-1:0]  SUB_ZERO_B    = 2'd1;
  localparam logic [SUB_W-1:0]  SUB_ONE       = 2'd2;
  localparam logic [SUB_W-1:0]  SUB_ID        = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROG_END = 2'd0,
    KIND_PACK     = 2'd1,
    KIND_SYSTEM   = 2'd2,
    KIND_PES      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_PACK   = 3'd1,
    PH_BODY   = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4
  } phase_t;

  // one parsed item: either a single byte or a full start code burst
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
    logic              last;
    logic              prefix;
    logic [SKIP_W-1:0] skipped;
  } desc_t;

endpackage

// ===== rtl/core/pespf_if.sv =====
// valid/ready channel interfaces for the framer input and output
interface pespf_in_if;
  import pespf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pespf_out_if;
  import pespf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              first_byte;
  logic              last_byte;
  logic [KIND_W-1:0] packet_kind;
  logic [SKIP_W-1:0] skipped_count;

  modport source (output valid, output out_byte, output first_byte, output last_byte,
                  output packet_kind, output skipped_count, input ready);
  modport sink   (input valid, input out_byte, input first_byte, input last_byte,
                  input packet_kind, input skipped_count, output ready);
endinterface

// ===== rtl/core/pespf_parser.sv =====
// start code hunt and packet length tracking, one input byte per cycle while take is high
module pespf_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [pespf_pkg::BYTE_W-1:0] in_byte,
  output logic                         push,
  output pespf_pkg::desc_t             desc
);
  import pespf_pkg::*;

  logic [23:0]       recent, recent_next;
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [HIDX_W-1:0] hidx, hidx_next;
  logic [SKIP_W-1:0] skip, skip_next;
  kind_t             kind, kind_next;

  logic [SKIP_W-1:0] skip_inc;
  logic [HIDX_W-1:0] hidx_inc;
  logic [LEN_W-1:0]  len_full;
  logic [LEN_W-1:0]  rem_dec;
  logic              emit;
  logic              done;
  kind_t             id_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent    <= WINDOW_RESET;
      phase     <= PH_HUNT;
      remaining <= '0;
      hidx      <= '0;
      skip      <= '0;
      kind      <= KIND_PROG_END;
    end else if (take) begin
      recent    <= recent_next;
      phase     <= phase_next;
      remaining <= remaining_next;
      hidx      <= hidx_next;
      skip      <= skip_next;
      kind      <= kind_next;
    end
  end

  always_comb begin
    skip_inc = (skip == SKIP_SAT) ? skip : skip + 1'b1;
    hidx_inc = hidx + 1'b1;
    len_full = {remaining[LEN_W-1:BYTE_W], in_byte};
    rem_dec  = (remaining != '0) ? remaining - 1'b1 : remaining;
    if (in_byte == ID_PROG_END)    id_kind = KIND_PROG_END;
    else if (in_byte == ID_PACK)   id_kind = KIND_PACK;
    else if (in_byte == ID_SYSTEM) id_kind = KIND_SYSTEM;
    else                           id_kind = KIND_PES;

    recent_next    = recent;
    phase_next     = phase;
    remaining_next = remaining;
    hidx_next      = hidx;
    skip_next      = skip;
    kind_next      = kind;
    emit           = 1'b0;
    done           = 1'b0;
    desc.data      = in_byte;
    desc.kind      = kind;
    desc.last      = 1'b0;
    desc.prefix    = 1'b0;
    desc.skipped   = '0;

    case (phase)
      PH_HUNT: begin
        recent_next = {recent[15:0], in_byte};
        skip_next   = skip_inc;
        if (recent == START_PREFIX && in_byte >= ID_PROG_END) begin
          emit        = 1'b1;
          kind_next   = id_kind;
          desc.kind   = id_kind;
          desc.prefix = 1'b1;
          desc.last   = (id_kind == KIND_PROG_END);
          if (skip_inc == SKIP_SAT)        desc.skipped = SKIP_SAT;
          else if (skip_inc >= PREFIX_LEN) desc.skipped = skip_inc - PREFIX_LEN;
          else                             desc.skipped = '0;
          case (id_kind)
            KIND_PROG_END: done = 1'b1;
            KIND_PACK: begin
              phase_next = PH_PACK;
              hidx_next  = '0;
            end
            default: phase_next = PH_LEN_HI;
          endcase
        end
      end
      PH_PACK: begin
        emit      = 1'b1;
        hidx_next = hidx_inc;
        if (hidx_inc >= PACK_FIXED) begin
          remaining_next = {{(LEN_W-3){1'b0}}, in_byte[2:0]};
          if (in_byte[2:0] == 3'd0) begin
            desc.last = 1'b1;
            done      = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_LEN_HI: begin
        emit           = 1'b1;
        remaining_next = {in_byte, {(LEN_W-BYTE_W){1'b0}}};
        phase_next     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        emit           = 1'b1;
        remaining_next = len_full;
        if (len_full == '0) begin
          desc.last = 1'b1;
          done      = 1'b1;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        emit           = 1'b1;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          desc.last = 1'b1;
          done      = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase

    if (done) begin
      phase_next     = PH_HUNT;
      recent_next    = WINDOW_RESET;
      skip_next      = '0;
      remaining_next = '0;
      hidx_next      = '0;
    end
  end

  assign push = take && emit;

endmodule

// ===== rtl/core/pespf_emitter.sv =====
// two-entry item queue that serializes start code bursts and single bytes onto the output
module pespf_emitter (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pespf_pkg::desc_t desc,
  output logic             can_take,
  pespf_out_if.source      dout
);
  import pespf_pkg::*;

  desc_t            head, skid;
  logic             head_valid, skid_valid;
  logic [SUB_W-1:0] sub;
  logic             fire;
  logic             pop;
  logic             head_free;

  assign fire      = dout.valid && dout.ready;
  assign pop       = fire && (!head.prefix || sub == SUB_ID);
  assign head_free = !head_valid || pop;
  assign can_take  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
      sub        <= SUB_ZERO_A;
    end else begin
      if (pop)       sub <= SUB_ZERO_A;
      else if (fire) sub <= sub + 1'b1;
      if (head_free) begin
        if (skid_valid) begin
          head_valid <= 1'b1;
          skid_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        head <= skid;
        skid <= desc;
      end else begin
        head <= desc;
      end
    end else if (push) begin
      skid <= desc;
    end
  end

  always_comb begin
    dout.valid         = head_valid;
    dout.packet_kind   = head.kind;
    dout.first_byte    = 1'b0;
    dout.last_byte     = 1'b0;
    dout.skipped_count = '0;
    dout.out_byte      = head.data;
    if (head.prefix) begin
      case (sub)
        SUB_ZERO_A: begin
          dout.out_byte      = PREFIX_ZERO;
          dout.first_byte    = 1'b1;
          dout.skipped_count = head.skipped;
        end
        SUB_ZERO_B: dout.out_byte = PREFIX_ZERO;
        SUB_ONE:    dout.out_byte = PREFIX_ONE;
        default: begin
          dout.out_byte  = head.data;
          dout.last_byte = head.last;
        end
      endcase
    end else begin
      dout.last_byte = head.last;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid) else $error("skid entry held without head entry");

  a_sub_in_burst: assert property (@(posedge clk) disable iff (rst)
    (sub != SUB_ZERO_A) |-> (head_valid && head.prefix))
    else $error("burst position set outside a start code burst");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid) else $error("item pushed into a full queue");

endmodule

// ===== rtl/core/pes_ps_packet_framer.sv =====
// top level of the program/pes stream start code packet framer
// Bytes enter on din one per cycle and leave framed on dout. A hunted byte
// that completes 00 00 01 with a stream id of B9 or above makes four output
// items (the start code bytes, the first one carrying the saturating count of
// bytes skipped before it); every byte inside a packet makes one item; other
// hunted bytes make none. Sustained rate is one input byte per cycle while the
// output is ready, with input stalls while a start code burst is sent, set by the
// single output port of the two-entry item queue. Each item is registered in
// the item queue before it leaves on dout.
module pes_ps_packet_framer (
  input  logic       clk,
  input  logic       rst,
  pespf_in_if.sink   din,
  pespf_out_if.source dout
);
  import pespf_pkg::*;

  logic  take;
  logic  push;
  logic  can_take;
  desc_t desc;

  assign din.ready = can_take;
  assign take      = din.valid && can_take;

  pespf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (din.in_byte),
    .push    (push),
    .desc    (desc)
  );

  pespf_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .desc     (desc),
    .can_take (can_take),
    .dout     (dout)
  );

endmodule

// ===== tb/pespf_framer_checker.sv =====
`timescale 1ns / 100ps
// checker for the packet framer: predicts framed output items from accepted bytes and compares
module pespf_framer_checker (
  input  logic        clk,
  input  logic        rst,
  pespf_in_if         din,
  pespf_out_if        dout,
  output int unsigned fail_count,
  output int unsigned pending
);
  import pespf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_first;
    logic              is_last;
    kind_t             kind;
    logic [SKIP_W-1:0] skipped;
  } framed_t;

  framed_t framed_q[$];

  logic [23:0]       window;
  phase_t            phase;
  logic [16:0]       remaining;
  logic [HIDX_W-1:0] hidx;
  logic [SKIP_W-1:0] skip_cnt;
  kind_t             kind;

  function automatic framed_t framed_item(input logic [BYTE_W-1:0] b, input logic is_first,
                                          input logic is_last, input logic [SKIP_W-1:0] skipped);
    framed_t it;
    it.data     = b;
    it.is_first = is_first;
    it.is_last  = is_last;
    it.kind     = kind;
    it.skipped  = skipped;
    return it;
  endfunction

  task automatic restart_hunt();
    phase     = PH_HUNT;
    window    = WINDOW_RESET;
    skip_cnt  = '0;
    remaining = '0;
    hidx      = '0;
  endtask

  task automatic frame_byte(input logic [BYTE_W-1:0] b);
    logic [31:0]       sync;
    logic [SKIP_W-1:0] skipped;
    logic              done;
    done = 1'b0;
    case (phase)
      PH_HUNT: begin
        sync   = {window, b};
        window = sync[23:0];
        if (skip_cnt != SKIP_SAT) skip_cnt = skip_cnt + 1'b1;
        if (sync[31:8] == START_PREFIX && b >= ID_PROG_END) begin
          // the count includes the prefix bytes and the id
          if (skip_cnt == SKIP_SAT) skipped = SKIP_SAT;
          else skipped = (skip_cnt >= PREFIX_LEN) ? skip_cnt - PREFIX_LEN : '0;
          kind = (b == ID_PROG_END) ? KIND_PROG_END :
                 (b == ID_PACK)     ? KIND_PACK :
                 (b == ID_SYSTEM)   ? KIND_SYSTEM : KIND_PES;
          framed_q.push_back(framed_item(PREFIX_ZERO, 1'b1, 1'b0, skipped));
          framed_q.push_back(framed_item(PREFIX_ZERO, 1'b0, 1'b0, '0));
          framed_q.push_back(framed_item(PREFIX_ONE, 1'b0, 1'b0, '0));
          framed_q.push_back(framed_item(b, 1'b0, kind == KIND_PROG_END, '0));
          if (kind == KIND_PROG_END) begin
            restart_hunt();
          end else if (kind == KIND_PACK) begin
            phase = PH_PACK;
            hidx  = '0;
          end else begin
            phase = PH_LEN_HI;
          end
        end
      end
      PH_PACK: begin
        hidx = hidx + 1'b1;
        if (hidx >= PACK_FIXED) begin
          remaining = {14'd0, b[2:0]};
          if (remaining == '0) done = 1'b1;
          else phase = PH_BODY;
        end
        framed_q.push_back(framed_item(b, 1'b0, done, '0));
      end
      PH_LEN_HI: begin
        remaining = {1'b0, b, 8'h00};
        phase     = PH_LEN_LO;
        framed_q.push_back(framed_item(b, 1'b0, 1'b0, '0));
      end
      PH_LEN_LO: begin
        remaining = remaining | {9'd0, b};
        done      = (remaining == '0);
        framed_q.push_back(framed_item(b, 1'b0, done, '0));
        if (!done) phase = PH_BODY;
      end
      PH_BODY: begin
        if (remaining != '0) remaining = remaining - 1'b1;
        done = (remaining == '0);
        framed_q.push_back(framed_item(b, 1'b0, done, '0));
      end
      default: begin
        restart_hunt();
      end
    endcase
    if (done) restart_hunt();
  endtask

  task automatic compare_field(input string name, input logic [SKIP_W-1:0] want,
                               input logic [SKIP_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_item();
    framed_t want;
    if (framed_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected item, expected none actual out_byte %h first %b last %b",
               $time, dout.out_byte, dout.first_byte, dout.last_byte);
    end else begin
      want = framed_q.pop_front();
      compare_field("out_byte", SKIP_W'(want.data), SKIP_W'(dout.out_byte));
      compare_field("first_byte", SKIP_W'(want.is_first), SKIP_W'(dout.first_byte));
      compare_field("last_byte", SKIP_W'(want.is_last), SKIP_W'(dout.last_byte));
      compare_field("packet_kind", SKIP_W'(want.kind), SKIP_W'(dout.packet_kind));
      compare_field("skipped_count", want.skipped, dout.skipped_count);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      framed_q.delete();
      restart_hunt();
      kind       = KIND_PROG_END;
      fail_count = 0;
    end else begin
      if (din.valid && din.ready) frame_byte(din.in_byte);
      if (dout.valid && dout.ready) check_item();
    end
    pending = framed_q.size();
  end

endmodule

// ===== tb/pes_ps_packet_framer_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the packet framer: byte stream stimulus, watchdog and verdict
module pes_ps_packet_framer_tb;
  import pespf_pkg::*;

  localparam int unsigned RANDOM_BYTES = 80;
  localparam int unsigned QUIET_AFTER  = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        quiet;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent;
  int unsigned idle_cycles;

  pespf_in_if  din ();
  pespf_out_if dout ();

  pes_ps_packet_framer i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  pespf_framer_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL pes_ps_packet_framer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dout.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!quiet && $urandom_range(3, 0) == 0) begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end
      dout.ready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    din.valid   <= 1'b1;
    din.in_byte <= b;
    do @(posedge clk); while (!din.ready);
    sent++;
  endtask

  task automatic send_prefix(input logic [BYTE_W-1:0] id);
    send_byte(PREFIX_ZERO);
    send_byte(PREFIX_ZERO);
    send_byte(PREFIX_ONE);
    send_byte(id);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] stuff;
    send_prefix(id);
    if (id == ID_PACK) begin
      repeat (9) send_byte(8'($urandom_range(255, 0)));
      stuff = 8'($urandom_range(255, 0));
      send_byte(stuff);
      repeat (stuff[2:0]) send_byte(8'($urandom_range(255, 0)));
    end else if (id != ID_PROG_END) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      repeat (len) send_byte(8'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] id;
    int unsigned       start;
    rst         <= 1'b1;
    din.valid   <= 1'b0;
    din.in_byte <= '0;
    quiet = 1'b0;
    sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // program end right after reset
    send_packet(ID_PROG_END, '0);
    // rejected id whose tail overlaps the next prefix, then zero-length system header
    send_prefix(PREFIX_ZERO);
    send_byte(PREFIX_ZERO);
    send_byte(PREFIX_ONE);
    send_byte(ID_SYSTEM);
    send_byte(8'h00);
    send_byte(8'h00);
    // pack header of all ones with no stuffing
    send_prefix(ID_PACK);
    repeat (9) send_byte(8'hFF);
    send_byte(8'hF8);

    start = sent;
    while (sent - start < RANDOM_BYTES) begin
      if (sent - start >= QUIET_AFTER) quiet = 1'b1;
      case ($urandom_range(9, 0))
        0: begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
        end
        1: begin
          send_byte(PREFIX_ZERO);
          send_byte(PREFIX_ZERO);
          if ($urandom_range(1, 0)) send_byte(PREFIX_ONE);
          send_byte(8'($urandom_range(ID_PROG_END - 1, 0)));
        end
        default: begin
          case ($urandom_range(5, 0))
            0: id = ID_PROG_END;
            1: id = ID_PACK;
            2: id = ID_SYSTEM;
            3: id = ID_PES_FIRST;
            4: id = 8'hFF;
            default: id = 8'($urandom_range(8'hFF, ID_PES_FIRST));
          endcase
          send_packet(id, LEN_W'($urandom_range(15, 0)));
        end
      endcase
    end
    // nonzero length high byte, packet still open when the stream stops
    quiet = 1'b1;
    send_prefix(ID_PES_FIRST);
    send_byte(8'h01);
    send_byte(8'($urandom_range(3, 0)));
    repeat (8) send_byte(8'($urandom_range(255, 0)));
    din.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS pes_ps_packet_framer");
    end else begin
      $display("FAIL pes_ps_packet_framer");
    end
    $finish;
  end

endmodule
